>>> design/lfu_pkg.sv
// Shared constants, packet and write-back types for the LFU cache engine.
`default_nettype none

package lfu_pkg;

	localparam int ENTRIES    = 16;
	localparam int COUNT_BITS = 16;
	localparam int STAMP_BITS = 48;
	localparam int KEY_W      = 32;
	localparam int DATA_W     = 32;
	localparam int CAP_W      = 5;
	localparam int IDX_W      = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int USED_W     = $clog2(ENTRIES + 1);
	localparam int CMP_W      = (USED_W > CAP_W) ? USED_W : CAP_W;

	localparam logic [CAP_W-1:0]      CAP_RESET = CAP_W'(16);
	localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
	localparam logic [COUNT_BITS-1:0] COUNT_ONE = COUNT_BITS'(1);

	// operation codes on the func field
	localparam logic FUNC_GET = 1'b0;
	localparam logic FUNC_PUT = 1'b1;

	// search packet handed from cell to cell
	typedef struct packed {
		logic                  active;
		logic [KEY_W-1:0]      key;
		logic                  found;
		logic [IDX_W-1:0]      found_idx;
		logic [DATA_W-1:0]     found_data;
		logic                  victim_valid;
		logic [IDX_W-1:0]      victim_idx;
		logic [COUNT_BITS-1:0] victim_cnt;
		logic [STAMP_BITS-1:0] victim_stamp;
		logic                  free_valid;
		logic [IDX_W-1:0]      free_idx;
		logic [USED_W-1:0]     used;
	} lfu_pkt_t;

	// write-back command broadcast to every cell
	typedef struct packed {
		logic                  en;
		logic [IDX_W-1:0]      idx;
		logic                  insert;
		logic                  write_data;
		logic [KEY_W-1:0]      key;
		logic [DATA_W-1:0]     data;
		logic [STAMP_BITS-1:0] stamp;
	} lfu_wb_t;

endpackage

`default_nettype wire

>>> design/lfu_if.sv
// Valid/ready channel interfaces for requests and responses.
`default_nettype none

interface lfu_req_if;
	logic                      valid;
	logic                      ready;
	logic                      func;
	logic [lfu_pkg::KEY_W-1:0]  key;
	logic [lfu_pkg::DATA_W-1:0] value;

	modport source (output valid, output func, output key, output value, input ready);
	modport sink   (input valid, input func, input key, input value, output ready);
endinterface

interface lfu_rsp_if;
	logic                      valid;
	logic                      ready;
	logic                      hit;
	logic [lfu_pkg::DATA_W-1:0] read_value;
	logic                      evicted;

	modport source (output valid, output hit, output read_value, output evicted, input ready);
	modport sink   (input valid, input hit, input read_value, input evicted, output ready);
endinterface

`default_nettype wire

>>> design/lfu_cell.sv
// One cache entry: holds its state, updates the passing search packet.
`default_nettype none

module lfu_cell (
	input  wire                       clk,
	input  wire                       arst_n,
	input  wire  [lfu_pkg::IDX_W-1:0] cell_idx,
	input  lfu_pkg::lfu_pkt_t         pkt_in,
	input  lfu_pkg::lfu_wb_t          wb,
	output lfu_pkg::lfu_pkt_t         pkt_out
);
	import lfu_pkg::*;

	logic                  valid_q;
	logic [KEY_W-1:0]      key_q;
	logic [DATA_W-1:0]     data_q;
	logic [COUNT_BITS-1:0] cnt_q;
	logic [STAMP_BITS-1:0] stamp_q;
	lfu_pkt_t              pkt_q;
	lfu_pkt_t              pkt_nxt;
	logic                  wb_hit;
	logic                  older;

	assign wb_hit = wb.en && (wb.idx == cell_idx);

	// lower count wins, then older stamp
	assign older = !pkt_in.victim_valid ||
		(cnt_q < pkt_in.victim_cnt) ||
		((cnt_q == pkt_in.victim_cnt) && (stamp_q < pkt_in.victim_stamp));

	// fold this entry into the packet
	always_comb begin
		pkt_nxt = pkt_in;
		if (pkt_in.active) begin
			if (valid_q) begin
				pkt_nxt.used = pkt_in.used + USED_W'(1);
				if (!pkt_in.found && (key_q == pkt_in.key)) begin
					pkt_nxt.found      = 1'b1;
					pkt_nxt.found_idx  = cell_idx;
					pkt_nxt.found_data = data_q;
				end
				if (older) begin
					pkt_nxt.victim_valid = 1'b1;
					pkt_nxt.victim_idx   = cell_idx;
					pkt_nxt.victim_cnt   = cnt_q;
					pkt_nxt.victim_stamp = stamp_q;
				end
			end else if (!pkt_in.free_valid) begin
				pkt_nxt.free_valid = 1'b1;
				pkt_nxt.free_idx   = cell_idx;
			end
		end
	end

	// packet stage and valid mark
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pkt_q   <= '0;
			valid_q <= 1'b0;
		end else begin
			pkt_q <= pkt_nxt;
			if (wb_hit && wb.insert) begin
				valid_q <= 1'b1;
			end
		end
	end

	// entry payload write-back
	always_ff @(posedge clk) begin
		if (wb_hit) begin
			stamp_q <= wb.stamp;
			if (wb.insert) begin
				key_q  <= wb.key;
				data_q <= wb.data;
				cnt_q  <= COUNT_ONE;
			end else begin
				if (wb.write_data) begin
					data_q <= wb.data;
				end
				if (cnt_q != COUNT_MAX) begin
					cnt_q <= cnt_q + COUNT_ONE;
				end
			end
		end
	end

	assign pkt_out = pkt_q;

endmodule

`default_nettype wire

>>> design/lfu_cache_engine.sv
// Top level of the LFU cache engine: request intake, cell chain, decision, response.
//
//  channel  dir  signals                          transfer when
//  -------  ---  -------------------------------  --------------------
//  req      in   valid ready func key value       valid && ready
//  rsp      out  valid ready hit read_value evicted valid && ready
//  cfg      in   cfg_we cfg_wdata                 cfg_we high at clock
//
// A request transfer is registered into the head packet, passes the ENTRIES chain cells, the
// finished packet is latched and then the decision step raises response valid; intake reopens
// after the decision, write-back overlapping the next intake. With capacity 0 the chain is
// skipped and the request goes straight to the decision. A stalled response holds the decision step;
// a new request is taken while a response waits.
// arst_n clears valid marks, access clock, capacity (to 16) and all control.
`default_nettype none

module lfu_cache_engine (
	input  wire                       clk,
	input  wire                       arst_n,
	input  wire                       cfg_we,
	input  wire  [lfu_pkg::CAP_W-1:0] cfg_wdata,
	lfu_req_if.sink                   req,
	lfu_rsp_if.source                 rsp
);
	import lfu_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE   = 3'b001,
		ST_SCAN   = 3'b010,
		ST_DECIDE = 3'b100
	} state_t;

	state_t                state_q;
	logic [CAP_W-1:0]      cap_q;
	logic [STAMP_BITS-1:0] clock_q;
	logic                  func_q;
	logic [DATA_W-1:0]     value_q;
	logic                  bypass_q;
	lfu_pkt_t              head_q;
	lfu_pkt_t              tail_q;
	lfu_wb_t               wb_q;
	lfu_wb_t               wb_nxt;
	lfu_pkt_t              pkt_w [ENTRIES+1];

	logic                  rsp_valid_q;
	logic                  hit_q;
	logic [DATA_W-1:0]     rdata_q;
	logic                  evict_q;

	logic                  accept;
	logic                  decide_go;
	logic [CMP_W-1:0]      cap_eff;
	logic                  cap_zero;
	logic                  full;
	logic                  res_hit;
	logic [DATA_W-1:0]     res_rdata;
	logic                  res_evict;

	assign req.ready = (state_q == ST_IDLE);
	assign accept    = req.valid && req.ready;
	assign decide_go = (state_q == ST_DECIDE) && (!rsp_valid_q || rsp.ready);

	// capacity clipped to the table size
	always_comb begin
		cap_eff = CMP_W'(cap_q);
		if (cap_eff > CMP_W'(ENTRIES)) begin
			cap_eff = CMP_W'(ENTRIES);
		end
	end
	assign cap_zero = (cap_q == '0);
	assign full     = CMP_W'(tail_q.used) >= cap_eff;

	// chain of cells
	assign pkt_w[0] = head_q;
	for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
		lfu_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.cell_idx(IDX_W'(i)),
			.pkt_in  (pkt_w[i]),
			.wb      (wb_q),
			.pkt_out (pkt_w[i+1])
		);
	end

	// decision from the finished packet
	always_comb begin
		res_hit   = 1'b0;
		res_rdata = '0;
		res_evict = 1'b0;
		wb_nxt       = '0;
		wb_nxt.key   = tail_q.key;
		wb_nxt.data  = value_q;
		wb_nxt.stamp = clock_q;
		if (!bypass_q) begin
			if (tail_q.found) begin
				res_hit           = 1'b1;
				wb_nxt.en         = 1'b1;
				wb_nxt.idx        = tail_q.found_idx;
				wb_nxt.write_data = (func_q == FUNC_PUT);
				if (func_q == FUNC_GET) begin
					res_rdata = tail_q.found_data;
				end
			end else if (func_q == FUNC_PUT) begin
				if (full && tail_q.victim_valid) begin
					res_evict     = 1'b1;
					wb_nxt.en     = 1'b1;
					wb_nxt.insert = 1'b1;
					wb_nxt.idx    = tail_q.victim_idx;
				end else if (tail_q.free_valid) begin
					wb_nxt.en     = 1'b1;
					wb_nxt.insert = 1'b1;
					wb_nxt.idx    = tail_q.free_idx;
				end
			end
		end
	end

	// control: state, capacity, access clock, head, write-back, response valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cap_q       <= CAP_RESET;
			clock_q     <= '0;
			head_q      <= '0;
			wb_q        <= '0;
			bypass_q    <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				cap_q <= cfg_wdata;
			end
			head_q.active <= 1'b0;
			wb_q.en       <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						bypass_q <= cap_zero;
						if (cap_zero) begin
							state_q <= ST_DECIDE;
						end else begin
							head_q        <= '0;
							head_q.active <= 1'b1;
							head_q.key    <= req.key;
							state_q       <= ST_SCAN;
						end
					end
				end
				ST_SCAN: begin
					if (pkt_w[ENTRIES].active) begin
						state_q <= ST_DECIDE;
					end
				end
				ST_DECIDE: begin
					if (decide_go) begin
						wb_q    <= wb_nxt;
						state_q <= ST_IDLE;
						if (wb_nxt.en) begin
							clock_q <= clock_q + STAMP_BITS'(1);
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
			if (decide_go) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// request payload, finished packet, response payload
	always_ff @(posedge clk) begin
		if (accept) begin
			func_q  <= req.func;
			value_q <= req.value;
			tail_q  <= '0;
		end
		if ((state_q == ST_SCAN) && pkt_w[ENTRIES].active) begin
			tail_q <= pkt_w[ENTRIES];
		end
		if (decide_go) begin
			hit_q   <= res_hit;
			rdata_q <= res_rdata;
			evict_q <= res_evict;
		end
	end

	assign rsp.valid      = rsp_valid_q;
	assign rsp.hit        = hit_q;
	assign rsp.read_value = rdata_q;
	assign rsp.evicted    = evict_q;

endmodule

`default_nettype wire

>>> design/lfu_chk.sv
// Port-level checks for the LFU cache engine, bound to the top level.
`default_nettype none

module lfu_chk (
	input wire                        clk,
	input wire                        arst_n,
	input wire                        req_valid,
	input wire                        req_ready,
	input wire                        rsp_valid,
	input wire                        rsp_ready,
	input wire                        rsp_hit,
	input wire  [lfu_pkg::DATA_W-1:0] rsp_read_value,
	input wire                        rsp_evicted
);

	// one access in flight: no intake right after a transfer in
	a_no_back_to_back: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("request taken while an access is in flight");

	// a new response comes from the decision step, when intake is closed
	a_rsp_after_work: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid) |-> $past(!req_ready))
		else $error("response appeared without a decision step");

	// a miss never returns data
	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_hit |-> rsp_read_value == '0)
		else $error("miss with nonzero read_value");

	// a hit never evicts
	a_hit_no_evict: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_hit |-> !rsp_evicted)
		else $error("hit reported an eviction");

	// stalled response stays valid and holds its read value
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_read_value))
		else $error("stalled response changed");

endmodule

bind lfu_cache_engine lfu_chk u_lfu_chk (
	.clk           (clk),
	.arst_n        (arst_n),
	.req_valid     (req.valid),
	.req_ready     (req.ready),
	.rsp_valid     (rsp.valid),
	.rsp_ready     (rsp.ready),
	.rsp_hit       (rsp.hit),
	.rsp_read_value(rsp.read_value),
	.rsp_evicted   (rsp.evicted)
);

`default_nettype wire
